[hw/rtl/qlt_pkg.sv]
// qlt_pkg: widths, register indexes, reset values and rounding constants
// for the q-learning table update block; no dependencies
`default_nettype none

package qlt_pkg;

  localparam int DATA_W      = 32;
  localparam int COEF_W      = 16;
  localparam int FRAC_W      = 16;
  localparam int ST_FIELD_W  = 6;
  localparam int ACT_FIELD_W = 4;

  localparam int DEF_NUM_STATES  = 64;
  localparam int DEF_NUM_ACTIONS = 16;

  // arithmetic widths
  localparam int PROD1_W = COEF_W + 1 + DATA_W;
  localparam int DIFF_W  = DATA_W + 2;
  localparam int PROD2_W = COEF_W + 1 + DIFF_W;
  localparam int NV_W    = DIFF_W + 2;

  localparam logic signed [PROD1_W:0] HALF1 = (PROD1_W + 1)'(32768);
  localparam logic signed [PROD2_W:0] HALF2 = (PROD2_W + 1)'(32768);
  localparam logic signed [NV_W-1:0]  SAT_MAX = NV_W'(64'sd2147483647);
  localparam logic signed [NV_W-1:0]  SAT_MIN = NV_W'(-64'sd2147483648);

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_LEARN_RATE = 2'd0,
    REG_DISCOUNT   = 2'd1,
    REG_INIT_VALUE = 2'd2
  } reg_idx_t;

  localparam logic [COEF_W-1:0]        LEARN_RATE_RST = 16'd6554;
  localparam logic [COEF_W-1:0]        DISCOUNT_RST   = 16'd58982;
  localparam logic signed [DATA_W-1:0] INIT_VALUE_RST = 32'sd0;

endpackage

`default_nettype wire

[hw/rtl/qlt_in_if.sv]
// qlt_in_if: input channel, one beat names an entry, a reward and a next state
// depends on qlt_pkg
`default_nettype none

interface qlt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [qlt_pkg::ST_FIELD_W-1:0]        cur_state;
  logic [qlt_pkg::ACT_FIELD_W-1:0]       taken_action;
  logic signed [qlt_pkg::DATA_W-1:0]     reward_value;
  logic [qlt_pkg::ST_FIELD_W-1:0]        following_state;

  modport source (output valid, cur_state, taken_action, reward_value, following_state,
                  input ready);
  modport sink   (input valid, cur_state, taken_action, reward_value, following_state,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/qlt_out_if.sv]
// qlt_out_if: result channel, one beat per update
// depends on qlt_pkg
`default_nettype none

interface qlt_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [qlt_pkg::DATA_W-1:0]     updated_value;
  logic signed [qlt_pkg::DATA_W-1:0]     row_maximum;
  logic [qlt_pkg::ACT_FIELD_W-1:0]       best_action;

  modport source (output valid, updated_value, row_maximum, best_action, input ready);
  modport sink   (input valid, updated_value, row_maximum, best_action, output ready);
endinterface

`default_nettype wire

[hw/rtl/q_learning_table_update.sv]
// q_learning_table_update: q-value table in one synchronous memory, row scan,
// fixed-point update and write-back; depends on qlt_pkg, qlt_in_if, qlt_out_if
//
//  channel  | dir | handshake                      | beat
//  in_bus   | in  | valid/ready                    | cur_state, taken_action, reward, next
//  out_bus  | out | valid/ready                    | updated_value, row_maximum, best_action
//  cfg_*    | in  | apb write at psel&penable&pwrite| learn_rate, discount, initial_value
//
// one item at a time: in_bus.ready stays low from accept until the write-back step is done,
// as the row scan runs through the single memory read port
// after reset and after each write of initial_value the table is filled, one entry a
// cycle, all NUM_STATES * 2**clog2(NUM_ACTIONS) entries (1024), with in_bus.ready low
// a result waiting in the output register stalls only the final write-back step
`default_nettype none

module q_learning_table_update #(
  parameter int NUM_STATES  = qlt_pkg::DEF_NUM_STATES,
  parameter int NUM_ACTIONS = qlt_pkg::DEF_NUM_ACTIONS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  qlt_in_if.sink                                in_bus,
  qlt_out_if.source                             out_bus,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [qlt_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [qlt_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [qlt_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int SW     = $clog2(NUM_STATES);
  localparam int AW     = $clog2(NUM_ACTIONS);
  localparam int CNT_W  = $clog2(NUM_ACTIONS + 1);
  localparam int ADDR_W = SW + AW;
  localparam int DEPTH  = NUM_STATES * (2 ** AW);
  localparam int DW     = qlt_pkg::DATA_W;
  localparam logic [CNT_W-1:0]  NA_CNT   = CNT_W'(NUM_ACTIONS);
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LAST, S_MUL1, S_DIFF, S_MUL2, S_WRITE, S_CLEAR
  } state_t;

  // index reduction tables
  logic [SW-1:0] st_map  [2**qlt_pkg::ST_FIELD_W];
  logic [AW-1:0] act_map [2**qlt_pkg::ACT_FIELD_W];

  always_comb begin
    for (int i = 0; i < 2**qlt_pkg::ST_FIELD_W; i++) begin
      st_map[i] = SW'(i % NUM_STATES);
    end
    for (int j = 0; j < 2**qlt_pkg::ACT_FIELD_W; j++) begin
      act_map[j] = AW'(j % NUM_ACTIONS);
    end
  end

  state_t                            state_r, state_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]                 clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0]                     s_r, s_nxt, ns_r, ns_nxt;
  logic [AW-1:0]                     a_r, a_nxt;
  logic signed [DW-1:0]              reward_r, reward_nxt;
  logic                              rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]                  rd_tag_r, rd_tag_nxt;
  logic signed [DW-1:0]              max_r, max_nxt;
  logic [AW-1:0]                     best_r, best_nxt;
  logic signed [DW-1:0]              old_r, old_nxt;
  logic signed [qlt_pkg::PROD1_W-1:0] prod1_r, prod1_nxt;
  logic signed [qlt_pkg::DIFF_W-1:0]  diff_r, diff_nxt;
  logic signed [qlt_pkg::PROD2_W-1:0] prod2_r, prod2_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [DW-1:0]              out_val_r, out_val_nxt;
  logic signed [DW-1:0]              out_max_r, out_max_nxt;
  logic [AW-1:0]                     out_best_r, out_best_nxt;
  logic [qlt_pkg::COEF_W-1:0]        lr_r, lr_nxt, disc_r, disc_nxt;
  logic signed [DW-1:0]              init_r, init_nxt;

  // table memory
  logic signed [DW-1:0]              mem [DEPTH];
  logic signed [DW-1:0]              rdata_r;
  logic                              mem_we;
  logic [ADDR_W-1:0]                 mem_waddr, mem_raddr;
  logic signed [DW-1:0]              mem_wdata;

  // arithmetic
  logic signed [qlt_pkg::PROD1_W:0]  rnd1, sh1;
  logic signed [qlt_pkg::PROD2_W:0]  rnd2, sh2;
  logic signed [qlt_pkg::NV_W-1:0]   nv;
  logic signed [DW-1:0]              nv_sat;
  logic                              out_free, cfg_wr, in_fire;

  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  always_comb begin
    rnd1   = $signed({prod1_r[qlt_pkg::PROD1_W-1], prod1_r}) + qlt_pkg::HALF1;
    sh1    = rnd1 >>> qlt_pkg::FRAC_W;
    rnd2   = $signed({prod2_r[qlt_pkg::PROD2_W-1], prod2_r}) + qlt_pkg::HALF2;
    sh2    = rnd2 >>> qlt_pkg::FRAC_W;
    nv     = qlt_pkg::NV_W'(old_r) + $signed(sh2[qlt_pkg::NV_W-1:0]);
    if (nv > qlt_pkg::SAT_MAX) begin
      nv_sat = DW'(qlt_pkg::SAT_MAX);
    end else if (nv < qlt_pkg::SAT_MIN) begin
      nv_sat = DW'(qlt_pkg::SAT_MIN);
    end else begin
      nv_sat = nv[DW-1:0];
    end
  end

  always_comb begin
    mem_raddr = (cnt_r < NA_CNT) ? {ns_r, cnt_r[AW-1:0]} : {s_r, a_r};
    mem_we    = (state_r == S_CLEAR) || ((state_r == S_WRITE) && out_free);
    mem_waddr = (state_r == S_CLEAR) ? clr_cnt_r : {s_r, a_r};
    mem_wdata = (state_r == S_CLEAR) ? init_r : nv_sat;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_cnt_nxt   = clr_cnt_r;
    s_nxt         = s_r;
    a_nxt         = a_r;
    ns_nxt        = ns_r;
    reward_nxt    = reward_r;
    max_nxt       = max_r;
    best_nxt      = best_r;
    old_nxt       = old_r;
    prod1_nxt     = prod1_r;
    diff_nxt      = diff_r;
    prod2_nxt     = prod2_r;
    out_val_nxt   = out_val_r;
    out_max_nxt   = out_max_r;
    out_best_nxt  = out_best_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    lr_nxt        = lr_r;
    disc_nxt      = disc_r;
    init_nxt      = init_r;
    rd_vld_nxt    = (state_r == S_READ);
    rd_tag_nxt    = cnt_r;

    // scan results and old entry come back in the cycle after the read
    if (rd_vld_r) begin
      if (rd_tag_r < NA_CNT) begin
        if ((rd_tag_r == '0) || (rdata_r > max_r)) begin
          max_nxt  = rdata_r;
          best_nxt = rd_tag_r[AW-1:0];
        end
      end else begin
        old_nxt = rdata_r;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          s_nxt      = st_map[in_bus.cur_state];
          a_nxt      = act_map[in_bus.taken_action];
          ns_nxt     = st_map[in_bus.following_state];
          reward_nxt = in_bus.reward_value;
          cnt_nxt    = '0;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == NA_CNT) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        prod1_nxt = $signed({1'b0, disc_r}) * max_r;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        diff_nxt  = qlt_pkg::DIFF_W'(reward_r) + $signed(sh1[qlt_pkg::DIFF_W-1:0])
                    - qlt_pkg::DIFF_W'(old_r);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        prod2_nxt = $signed({1'b0, lr_r}) * diff_r;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          out_val_nxt   = nv_sat;
          out_max_nxt   = max_r;
          out_best_nxt  = best_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == LAST_ADR) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        qlt_pkg::REG_LEARN_RATE: lr_nxt   = cfg_pwdata[qlt_pkg::COEF_W-1:0];
        qlt_pkg::REG_DISCOUNT:   disc_nxt = cfg_pwdata[qlt_pkg::COEF_W-1:0];
        qlt_pkg::REG_INIT_VALUE: begin
          init_nxt    = $signed(cfg_pwdata[DW-1:0]);
          state_nxt   = S_CLEAR;
          clr_cnt_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      rd_tag_r    <= '0;
      out_valid_r <= 1'b0;
      lr_r        <= qlt_pkg::LEARN_RATE_RST;
      disc_r      <= qlt_pkg::DISCOUNT_RST;
      init_r      <= qlt_pkg::INIT_VALUE_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_tag_r    <= rd_tag_nxt;
      out_valid_r <= out_valid_nxt;
      lr_r        <= lr_nxt;
      disc_r      <= disc_nxt;
      init_r      <= init_nxt;
      s_r         <= s_nxt;
      a_r         <= a_nxt;
      ns_r        <= ns_nxt;
      reward_r    <= reward_nxt;
      max_r       <= max_nxt;
      best_r      <= best_nxt;
      old_r       <= old_nxt;
      prod1_r     <= prod1_nxt;
      diff_r      <= diff_nxt;
      prod2_r     <= prod2_nxt;
      out_val_r   <= out_val_nxt;
      out_max_r   <= out_max_nxt;
      out_best_r  <= out_best_nxt;
    end
  end

  assign in_bus.ready          = (state_r == S_IDLE);
  assign out_bus.valid         = out_valid_r;
  assign out_bus.updated_value = out_val_r;
  assign out_bus.row_maximum   = out_max_r;
  assign out_bus.best_action   = qlt_pkg::ACT_FIELD_W'(out_best_r);
  assign cfg_pready            = 1'b1;

  always_comb begin
    unique case (cfg_paddr[3:2])
      qlt_pkg::REG_LEARN_RATE: cfg_prdata = qlt_pkg::CFG_DATA_W'(lr_r);
      qlt_pkg::REG_DISCOUNT:   cfg_prdata = qlt_pkg::CFG_DATA_W'(disc_r);
      qlt_pkg::REG_INIT_VALUE: cfg_prdata = init_r;
      default:                 cfg_prdata = '0;
    endcase
  end

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !mem_we)
    else $error("table write while a beat is accepted");

  a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WRITE))
    else $error("result appeared without a write-back step");

  a_best_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL1) |-> (CNT_W'(best_r) < NA_CNT))
    else $error("best action outside the row");

endmodule

`default_nettype wire
